>>> src/pal_pkg.sv
// shared types for the positional array list core
// request codes, sequencer states and the request/result records
// no dependencies
package pal_pkg;

  localparam int POS_W = 7;
  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_DELETE = 3'd1,
    FN_GET    = 3'd2,
    FN_LOCATE = 3'd3,
    FN_PREV   = 3'd4,
    FN_NEXT   = 3'd5,
    FN_CLEAR  = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_INS_SHIFT,
    ST_INS_WRITE,
    ST_DEL_FIRST,
    ST_DEL_SHIFT,
    ST_LOCATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t                     func;
    logic [POS_W-1:0]          position;
    logic signed [VAL_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic                      ok;
    logic signed [VAL_W-1:0]   read_value;
    logic [POS_W-1:0]          found_position;
    logic [POS_W-1:0]          list_length;
  } res_t;

endpackage

>>> src/pal_engine.sv
// list engine: entry memory, entry count and the sequencer that walks it
// one pointer and one compare are reused for shifting and searching
// depends on pal_pkg
module pal_engine import pal_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic idle,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  state_t state, state_next;

  logic [DATA_WIDTH-1:0]        mem [CAPACITY];
  logic signed [DATA_WIDTH-1:0] rdata;
  logic [AW-1:0]                raddr;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [DATA_WIDTH-1:0]        wdata;

  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         ptr, ptr_next;
  logic [POS_W-1:0]      pos_q, pos_q_next;
  logic [DATA_WIDTH-1:0] val_q, val_q_next;
  logic                  res_ok, res_ok_next;
  logic [VAL_W-1:0]      res_rd, res_rd_next;
  logic [POS_W-1:0]      res_found, res_found_next;

  logic [CMPW-1:0] pos_x, cnt_x;
  logic            ins_ok, rd_ok, prev_ok, next_ok, shift_need;
  logic [AW-1:0]   pos_m1;
  logic            more, match;
  logic [VAL_W-1:0] rd_ext;

  assign pos_x      = CMPW'(req.position);
  assign cnt_x      = CMPW'(count);
  assign ins_ok     = (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1)) && (cnt_x < CMPW'(CAPACITY));
  assign rd_ok      = (pos_x != '0) && (pos_x <= cnt_x);
  assign prev_ok    = (pos_x >= CMPW'(2)) && (pos_x <= cnt_x);
  assign next_ok    = (pos_x != '0) && (pos_x < cnt_x);
  assign shift_need = pos_x <= cnt_x;

  // stop address of the upward shift, i.e. the insert slot
  assign pos_m1 = AW'(CMPW'(pos_q) - CMPW'(1));
  assign more   = (CW'(ptr) + CW'(1)) < count;
  assign match  = rdata == val_q;
  assign rd_ext = VAL_W'(rdata);

  assign idle      = state == ST_IDLE;
  assign res_valid = state == ST_DONE;
  assign res.ok             = res_ok;
  assign res.read_value     = res_rd;
  assign res.found_position = res_found;
  assign res.list_length    = POS_W'(count);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    pos_q     <= pos_q_next;
    val_q     <= val_q_next;
    res_ok    <= res_ok_next;
    res_rd    <= res_rd_next;
    res_found <= res_found_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req.func)
            FN_INSERT: state_next = ins_ok ? (shift_need ? ST_INS_SHIFT : ST_INS_WRITE)
                                           : ST_DONE;
            FN_DELETE: state_next = rd_ok ? ST_DEL_FIRST : ST_DONE;
            FN_GET:    state_next = rd_ok ? ST_READ : ST_DONE;
            FN_PREV:   state_next = prev_ok ? ST_READ : ST_DONE;
            FN_NEXT:   state_next = next_ok ? ST_READ : ST_DONE;
            FN_LOCATE: state_next = (count != '0) ? ST_LOCATE : ST_DONE;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_INS_SHIFT: state_next = (ptr == pos_m1) ? ST_INS_WRITE : ST_INS_SHIFT;
      ST_INS_WRITE: state_next = ST_DONE;
      ST_READ:      state_next = ST_DONE;
      ST_DEL_FIRST: state_next = more ? ST_DEL_SHIFT : ST_DONE;
      ST_DEL_SHIFT: state_next = more ? ST_DEL_SHIFT : ST_DONE;
      ST_LOCATE:    state_next = (match || !more) ? ST_DONE : ST_LOCATE;
      ST_DONE:      state_next = res_ready ? ST_IDLE : ST_DONE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next     = count;
    ptr_next       = ptr;
    pos_q_next     = pos_q;
    val_q_next     = val_q;
    res_ok_next    = res_ok;
    res_rd_next    = res_rd;
    res_found_next = res_found;
    raddr          = ptr;
    we             = 1'b0;
    waddr          = ptr;
    wdata          = rdata;
    case (state)
      ST_IDLE: begin
        if (start) begin
          pos_q_next     = req.position;
          val_q_next     = DATA_WIDTH'(req.value);
          res_rd_next    = '0;
          res_found_next = '0;
          res_ok_next    = 1'b0;
          case (req.func)
            FN_INSERT: raddr = AW'(cnt_x - CMPW'(1));
            FN_DELETE: begin
              raddr       = AW'(pos_x - CMPW'(1));
              res_ok_next = rd_ok;
            end
            FN_GET: begin
              raddr       = AW'(pos_x - CMPW'(1));
              res_ok_next = rd_ok;
            end
            FN_PREV: begin
              raddr       = AW'(pos_x - CMPW'(2));
              res_ok_next = prev_ok;
            end
            FN_NEXT: begin
              raddr       = AW'(pos_x);
              res_ok_next = next_ok;
            end
            FN_LOCATE: begin
              raddr       = '0;
              res_ok_next = 1'b1;
            end
            FN_CLEAR: begin
              count_next  = '0;
              res_ok_next = 1'b1;
            end
            default: res_ok_next = 1'b0;
          endcase
          ptr_next = raddr;
        end
      end
      ST_INS_SHIFT: begin
        // rdata holds entry ptr, move it one slot up
        we    = 1'b1;
        waddr = ptr + AW'(1);
        raddr = ptr - AW'(1);
        if (ptr != pos_m1) begin
          ptr_next = ptr - AW'(1);
        end
      end
      ST_INS_WRITE: begin
        we          = 1'b1;
        waddr       = pos_m1;
        wdata       = val_q;
        count_next  = count + CW'(1);
        res_ok_next = 1'b1;
      end
      ST_READ: res_rd_next = rd_ext;
      ST_DEL_FIRST: begin
        res_rd_next = rd_ext;
        raddr       = ptr + AW'(1);
        if (more) begin
          ptr_next = ptr + AW'(1);
        end else begin
          count_next = count - CW'(1);
        end
      end
      ST_DEL_SHIFT: begin
        // rdata holds entry ptr, move it one slot down
        we    = 1'b1;
        waddr = ptr - AW'(1);
        raddr = ptr + AW'(1);
        if (more) begin
          ptr_next = ptr + AW'(1);
        end else begin
          count_next = count - CW'(1);
        end
      end
      ST_LOCATE: begin
        raddr = ptr + AW'(1);
        if (match) begin
          res_found_next = POS_W'({1'b0, ptr} + 1'b1);
        end else if (more) begin
          ptr_next = ptr + AW'(1);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

>>> src/positional_array_list_core.sv
// Positional array list core: an ordered list of signed words addressed by
// 1-based position, served one request at a time.
// Channels: s_tvalid/s_tready/s_tdata carry requests, m_tvalid/m_tready/
// m_tdata carry one result per request. A transfer happens on a rising edge
// with tvalid and tready both high.
// Codes: insert, delete, get, locate, prev, next, clear; an unused code gives
// ok low and leaves the list alone. Every result carries the new length.
// Insert at position p shifts the entries from p to the end up one slot and
// then writes the new word; delete shifts the entries after p down; locate
// scans from position 1 until a match or the end of the list. The walk goes
// one entry per cycle through the single read and single write port of the
// entry memory.
// s_tready is high only while the engine is idle. A finished result sits in
// the output register; while the receiver stalls the engine can take and
// work the next request, and holds its result until the register frees up.
// Reset empties the list (length 0) and drops any result not yet taken;
// entry contents are not cleared and need no clearing pass.
// depends on pal_pkg and pal_engine
module positional_array_list_core import pal_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // func[2:0], position[9:3], value[41:10], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // ok[0], read_value[32:1], found_position[39:33],
                                // list_length[46:40], zero pad
);

  req_t req;
  res_t res;
  logic start, idle, res_valid, res_ready;

  assign req.func     = func_t'(s_tdata[2:0]);
  assign req.position = s_tdata[9:3];
  assign req.value    = s_tdata[41:10];

  assign s_tready  = idle;
  assign start     = s_tvalid && idle;
  assign res_ready = !m_tvalid || m_tready;

  pal_engine #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .idle     (idle),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {1'b0, res.list_length, res.found_position, res.read_value, res.ok};
    end
  end

endmodule
